// ===== rtl/core/tfl_pkg.sv =====
// Shared types, constants and helper functions for the TCP flow table.
package tfl_pkg;

    // Table geometry. BUCKETS is a power of two so the bucket is the low hash bits.
    localparam int BUCKETS = 1024;
    localparam int ENTRIES = 3072;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int ENT_W   = $clog2(ENTRIES);
    localparam int LINK_W  = ENT_W + 1;

    localparam logic [LINK_W-1:0] LINK_NIL   = '1;
    localparam logic [LINK_W-1:0] ENTRIES_L  = LINK_W'(ENTRIES);
    localparam logic [LINK_W-1:0] BUCKETS_L  = LINK_W'(BUCKETS);
    localparam logic [31:0]       CRC32C_POLY = 32'h82F63B78;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_FULL   = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_LK_HEAD,
        S_LK_ENT,
        S_INS,
        S_INS_POP,
        S_INS_LINK,
        S_INS_FIX,
        S_RM_CHK,
        S_RM_NX,
        S_RM_PV,
        S_DONE
    } fsm_t;

    // One pool entry as stored in the entry memory.
    typedef struct packed {
        logic              in_use;
        logic [BKT_W-1:0]  bucket;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
        logic [31:0]       ports;
        logic [63:0]       addrs;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // A link points at an entry when it is below the pool size.
    function automatic logic link_valid(input logic [LINK_W-1:0] l);
        return l < ENTRIES_L;
    endfunction

    // Reflected CRC32C over one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC32C_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/tfl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tfl_hash.sv =====
// Bucket hash unit: CRC32C one byte per cycle, or a plain XOR.
module tfl_hash (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 mode,
    input  logic [31:0]          src_addr,
    input  logic [31:0]          dst_addr,
    input  logic [15:0]          src_port,
    input  logic [15:0]          dst_port,
    output logic                 done,
    output logic [tfl_pkg::BKT_W-1:0] bucket
);
    import tfl_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic [63:0] data_reg, data_next;
    logic [31:0] addr_x;
    logic [31:0] port_x;

    assign addr_x = src_addr ^ dst_addr;
    assign port_x = {16'd0, src_port ^ dst_port};

    // The address word is fed first, then the port word, low byte first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        data_next = data_reg;
        if (start)
        begin
            if (mode)
            begin
                busy_next = 1'b1;
                cnt_next  = 3'd0;
                crc_next  = 32'd0;
                data_next = {port_x, addr_x};
            end
            else
            begin
                crc_next  = addr_x ^ port_x;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            crc_next  = crc_byte(crc_reg, data_reg[7:0]);
            data_next = data_reg >> 8;
            cnt_next  = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg  <= crc_next;
        data_reg <= data_next;
    end

    assign done   = done_reg;
    assign bucket = crc_reg[BKT_W-1:0];

endmodule

// ===== rtl/core/tcp_flow_table.sv =====
// Top level of the TCP flow table: request sequencer around the bucket and entry memories.
//
// Usage: one request item enters on the in_valid/in_stall channel (lookup, insert or
// remove) and exactly one result item leaves on the out_valid/out_stall channel.
// The block works on one request at a time; in_stall is low only while it is idle.
// Lookup: the hash (8 byte steps and the done register in CRC32C mode, only the done
// register in XOR mode), a bucket head read, then one entry read per chain element, over
// the forward chain and then again, from the bucket head, for the reversed tuple, and
// at last the load of the result register. An insert ends early when the pool is full,
// and a remove ends early when the index is out of range.
// The next request item can be accepted in the cycle after the result is loaded.
// The rate is set by the hash unit (one byte per cycle) and the single read port of
// the entry memory, which is read once per chain element.
// After reset the block runs a clearing pass over the 3072 entries of the entry memory
// (and the 1024 bucket heads within it) and accepts no request item during it; hash_mode
// resets to CRC32C; the user must write it only while no item is in flight (unenforced).
// A finished result waits in the output register while out_stall is high; a following
// result waits in the sequencer, which holds in_stall high until the register frees.
module tcp_flow_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic [31:0]                src_addr,
    input  logic [31:0]                dst_addr,
    input  logic [15:0]                src_port,
    input  logic [15:0]                dst_port,
    input  logic [tfl_pkg::ENT_W-1:0]  remove_index,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic                       direct_match,
    output logic [tfl_pkg::ENT_W-1:0]  entry_index,
    output logic [tfl_pkg::BKT_W-1:0]  bucket_index
);
    import tfl_pkg::*;

    fsm_t              state_reg, state_next;
    logic              hash_mode_reg;
    logic [1:0]        req_reg, req_next;
    logic [31:0]       sa_reg, da_reg;
    logic [15:0]       sp_reg, dp_reg;
    logic [BKT_W-1:0]  bkt_reg, bkt_next;
    logic [ENT_W-1:0]  ent_reg, ent_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] nx_reg, nx_next;
    logic [LINK_W-1:0] pv_reg, pv_next;
    logic              pass_reg, pass_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_dir_reg, res_dir_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] fresh_reg, fresh_next;
    logic [LINK_W-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic              load_out;
    logic [1:0]        out_status_reg;
    logic              out_dir_reg;
    logic [ENT_W-1:0]  out_ent_reg;
    logic [BKT_W-1:0]  out_bkt_reg;

    logic              accept;
    logic              h_start, h_done;
    logic [BKT_W-1:0]  h_bucket;

    logic              bh_we, bh_re;
    logic [BKT_W-1:0]  bh_waddr, bh_raddr;
    logic [LINK_W-1:0] bh_wdata, bh_rdata;

    logic              em_we, em_re;
    logic [ENT_W-1:0]  em_waddr, em_raddr;
    entry_t            em_wdata, em_rd;
    logic [ENTRY_W-1:0] em_rdata;

    logic [63:0]       key_addrs;
    logic [31:0]       key_ports;
    entry_t            new_entry;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign h_start  = accept && (req_type == REQ_LOOKUP || req_type == REQ_INSERT);
    assign em_rd    = entry_t'(em_rdata);

    // Search key: tuple as given on the first pass, reversed on the second.
    assign key_addrs = pass_reg ? {da_reg, sa_reg} : {sa_reg, da_reg};
    assign key_ports = pass_reg ? {dp_reg, sp_reg} : {sp_reg, dp_reg};

    always_comb
    begin
        new_entry.in_use = 1'b1;
        new_entry.bucket = bkt_reg;
        new_entry.prev   = LINK_NIL;
        new_entry.next   = bh_rdata;
        new_entry.ports  = {sp_reg, dp_reg};
        new_entry.addrs  = {sa_reg, da_reg};
    end

    tfl_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (h_start),
        .mode     (hash_mode_reg),
        .src_addr (src_addr),
        .dst_addr (dst_addr),
        .src_port (src_port),
        .dst_port (dst_port),
        .done     (h_done),
        .bucket   (h_bucket)
    );

    tfl_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_bucket_ram (
        .clk   (clk),
        .we    (bh_we),
        .waddr (bh_waddr),
        .wdata (bh_wdata),
        .re    (bh_re),
        .raddr (bh_raddr),
        .rdata (bh_rdata)
    );

    tfl_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (em_wdata),
        .re    (em_re),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            hash_mode_reg <= cfg_wdata;
        end
    end

    // Input item capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sa_reg <= src_addr;
            da_reg <= dst_addr;
            sp_reg <= src_port;
            dp_reg <= dst_port;
        end
    end

    // Sequencer: next state, memory accesses and result fields.
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        bkt_next        = bkt_reg;
        ent_next        = ent_reg;
        cur_next        = cur_reg;
        nx_next         = nx_reg;
        pv_next         = pv_reg;
        pass_next       = pass_reg;
        res_status_next = res_status_reg;
        res_dir_next    = res_dir_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        clr_next        = clr_reg;
        load_out        = 1'b0;
        bh_we           = 1'b0;
        bh_waddr        = bkt_reg;
        bh_wdata        = LINK_NIL;
        bh_re           = 1'b0;
        bh_raddr        = h_bucket;
        em_we           = 1'b0;
        em_waddr        = ent_reg;
        em_wdata        = em_rd;
        em_re           = 1'b0;
        em_raddr        = cur_reg[ENT_W-1:0];

        unique case (state_reg)
            // Clear every entry, and every bucket head on the way.
            S_CLEAR:
            begin
                em_we    = 1'b1;
                em_waddr = clr_reg[ENT_W-1:0];
                em_wdata = '0;
                if (clr_reg < BUCKETS_L)
                begin
                    bh_we    = 1'b1;
                    bh_waddr = clr_reg[BKT_W-1:0];
                    bh_wdata = LINK_NIL;
                end
                clr_next = clr_reg + LINK_W'(1);
                if (clr_reg == ENTRIES_L - LINK_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req_type;
                    res_status_next = ST_MISS;
                    res_dir_next    = 1'b0;
                    ent_next        = '0;
                    bkt_next        = '0;
                    pass_next       = 1'b0;
                    unique case (req_type)
                        REQ_LOOKUP, REQ_INSERT:
                        begin
                            state_next = S_HASH;
                        end
                        REQ_REMOVE:
                        begin
                            ent_next = remove_index;
                            if (link_valid({1'b0, remove_index}))
                            begin
                                em_re      = 1'b1;
                                em_raddr   = remove_index;
                                state_next = S_RM_CHK;
                            end
                            else
                            begin
                                res_status_next = ST_UNUSED;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Wait for the bucket, then fetch its head.
            S_HASH:
            begin
                if (h_done)
                begin
                    bkt_next = h_bucket;
                    bh_re    = 1'b1;
                    bh_raddr = h_bucket;
                    state_next = (req_reg == REQ_LOOKUP) ? S_LK_HEAD : S_INS;
                end
            end

            // Start a chain walk from the bucket head.
            S_LK_HEAD:
            begin
                if (link_valid(bh_rdata))
                begin
                    cur_next   = bh_rdata;
                    em_re      = 1'b1;
                    em_raddr   = bh_rdata[ENT_W-1:0];
                    state_next = S_LK_ENT;
                end
                else if (!pass_reg)
                begin
                    pass_next = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Compare one chain element and follow its next link.
            S_LK_ENT:
            begin
                if (em_rd.addrs == key_addrs && em_rd.ports == key_ports)
                begin
                    res_status_next = ST_OK;
                    res_dir_next    = !pass_reg;
                    ent_next        = cur_reg[ENT_W-1:0];
                    state_next      = S_DONE;
                end
                else if (link_valid(em_rd.next))
                begin
                    cur_next = em_rd.next;
                    em_re    = 1'b1;
                    em_raddr = em_rd.next[ENT_W-1:0];
                end
                else if (!pass_reg)
                begin
                    pass_next  = 1'b1;
                    state_next = S_LK_HEAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Allocate from the free list, else a fresh entry, else report a full pool.
            S_INS:
            begin
                if (link_valid(free_head_reg))
                begin
                    ent_next   = free_head_reg[ENT_W-1:0];
                    em_re      = 1'b1;
                    em_raddr   = free_head_reg[ENT_W-1:0];
                    state_next = S_INS_POP;
                end
                else if (fresh_reg < ENTRIES_L)
                begin
                    ent_next   = fresh_reg[ENT_W-1:0];
                    fresh_next = fresh_reg + LINK_W'(1);
                    state_next = S_INS_LINK;
                end
                else
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
            end

            S_INS_POP:
            begin
                free_head_next = em_rd.next;
                state_next     = S_INS_LINK;
            end

            // Write the new entry at the chain head and fetch the old head.
            S_INS_LINK:
            begin
                em_we    = 1'b1;
                em_waddr = ent_reg;
                em_wdata = new_entry;
                bh_we    = 1'b1;
                bh_waddr = bkt_reg;
                bh_wdata = {1'b0, ent_reg};
                res_status_next = ST_OK;
                if (link_valid(bh_rdata))
                begin
                    cur_next   = bh_rdata;
                    em_re      = 1'b1;
                    em_raddr   = bh_rdata[ENT_W-1:0];
                    state_next = S_INS_FIX;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_INS_FIX:
            begin
                em_we         = 1'b1;
                em_waddr      = cur_reg[ENT_W-1:0];
                em_wdata      = em_rd;
                em_wdata.prev = {1'b0, ent_reg};
                state_next    = S_DONE;
            end

            // Reject an unused entry; else free it and start unlinking it from its neighbors.
            S_RM_CHK:
            begin
                if (!em_rd.in_use)
                begin
                    res_status_next = ST_UNUSED;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_status_next = ST_OK;
                    bkt_next        = em_rd.bucket;
                    nx_next         = em_rd.next;
                    pv_next         = em_rd.prev;
                    em_we           = 1'b1;
                    em_waddr        = ent_reg;
                    em_wdata        = em_rd;
                    em_wdata.in_use = 1'b0;
                    em_wdata.next   = free_head_reg;
                    free_head_next  = {1'b0, ent_reg};
                    if (!link_valid(em_rd.prev))
                    begin
                        bh_we    = 1'b1;
                        bh_waddr = em_rd.bucket;
                        bh_wdata = em_rd.next;
                    end
                    if (link_valid(em_rd.next))
                    begin
                        em_re      = 1'b1;
                        em_raddr   = em_rd.next[ENT_W-1:0];
                        state_next = S_RM_NX;
                    end
                    else if (link_valid(em_rd.prev))
                    begin
                        em_re      = 1'b1;
                        em_raddr   = em_rd.prev[ENT_W-1:0];
                        state_next = S_RM_PV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_RM_NX:
            begin
                em_we         = 1'b1;
                em_waddr      = nx_reg[ENT_W-1:0];
                em_wdata      = em_rd;
                em_wdata.prev = pv_reg;
                if (link_valid(pv_reg))
                begin
                    em_re      = 1'b1;
                    em_raddr   = pv_reg[ENT_W-1:0];
                    state_next = S_RM_PV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_RM_PV:
            begin
                em_we         = 1'b1;
                em_waddr      = pv_reg[ENT_W-1:0];
                em_wdata      = em_rd;
                em_wdata.next = nx_reg;
                state_next    = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= LINK_NIL;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        bkt_reg        <= bkt_next;
        ent_reg        <= ent_next;
        cur_reg        <= cur_next;
        nx_reg         <= nx_next;
        pv_reg         <= pv_next;
        pass_reg       <= pass_next;
        res_status_reg <= res_status_next;
        res_dir_reg    <= res_dir_next;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_dir_reg    <= res_dir_reg;
            out_ent_reg    <= ent_reg;
            out_bkt_reg    <= bkt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign direct_match = out_dir_reg;
    assign entry_index  = out_ent_reg;
    assign bucket_index = out_bkt_reg;

endmodule

// ===== rtl/core/tfl_checker.sv =====
// Port-level assertions for the TCP flow table, bound to the top level.
module tfl_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [1:0]                 status,
    input  logic                       direct_match,
    input  logic [tfl_pkg::ENT_W-1:0]  entry_index,
    input  logic [tfl_pkg::BKT_W-1:0]  bucket_index
);
    import tfl_pkg::*;

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(entry_index)
            && $stable(bucket_index) && $stable(direct_match))
        else $error("stalled result payload changed");

    // Only a successful request can report a direct match.
    a_dir_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !direct_match)
        else $error("direction set on a failed request");

    // A full pool reports no entry.
    a_full_ent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_index == '0)
        else $error("entry index set on full pool");

    // A rejected remove reports no bucket.
    a_unused_bkt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_UNUSED |-> bucket_index == '0)
        else $error("bucket index set on rejected remove");

endmodule

bind tcp_flow_table tfl_checker u_tfl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .direct_match (direct_match),
    .entry_index  (entry_index),
    .bucket_index (bucket_index)
);
